@@ rtl/rpu_pkg.sv @@
// ----------------------------------------------------------------------------
// rpu_pkg
// Shared constants, codes and types of the reaction propensity update block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpu_pkg;

  localparam int BINS       = 64;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_W     = (BINS > 1) ? $clog2(BINS) : 1;

  localparam int CNT_W  = 16;
  localparam int PROP_W = 48;
  localparam int SUM_W  = 54;
  localparam int TOT_W  = 22;
  localparam int DEC_W  = 23;
  localparam int RATE_W = 32;
  localparam int CMD_W  = 3;
  localparam int BIN_W  = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'((64'd1 << COUNT_BITS) - 64'd1);

  // event commands
  localparam logic [CMD_W-1:0] CMD_MAKE_X  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DECAY_X = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MAKE_Y  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TRIMER  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RATE = 1'd1;

  typedef struct packed {
    logic [CNT_W-1:0]  x;
    logic [CNT_W-1:0]  y;
    logic [PROP_W-1:0] prop;
  } bin_rec_t;

  localparam int REC_W = $bits(bin_rec_t);

endpackage

`default_nettype wire

@@ rtl/rpu_ram.sv @@
// ----------------------------------------------------------------------------
// rpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/reaction_propensity_update_top.sv @@
// ----------------------------------------------------------------------------
// reaction_propensity_update_top
// Per-bin count and propensity update engine for a two-species reaction model.
// ----------------------------------------------------------------------------
// Pipeline: the bin read is issued at the accept edge, then the CALC step (calc
//   and first multiply), the MUL step (second multiply and jump products) and
//   the FIN step (write-back and result register).
// Throughput: a new item is accepted only after write-back of the last, set by
//   the read-modify-write of the bin RAM and the two dependent multiplies of
//   x*(x-1)*y; a stalled result holds the next item off until it is taken.
// Reset (synchronous, rst_n low): rates, totals and sum cleared; per-bin valid
//   flags cleared at once, so every bin reads as zero counts. No clearing pass.
`default_nettype none

module reaction_propensity_update_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [rpu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rpu_pkg::RATE_W-1:0]       cfg_wdata,
  // event input
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rpu_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [rpu_pkg::BIN_W-1:0]        in_bin,
  input  wire logic [rpu_pkg::CNT_W-1:0]        in_load_x,
  input  wire logic [rpu_pkg::CNT_W-1:0]        in_load_y,
  // result output
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rpu_pkg::CNT_W-1:0]             out_bin_x,
  output logic [rpu_pkg::CNT_W-1:0]             out_bin_y,
  output logic [rpu_pkg::PROP_W-1:0]            out_bin_propensity,
  output logic [rpu_pkg::SUM_W-1:0]             out_trimer_sum,
  output logic [rpu_pkg::SUM_W-1:0]             out_x_jump_total,
  output logic [rpu_pkg::SUM_W-1:0]             out_y_jump_total,
  output logic [rpu_pkg::DEC_W-1:0]             out_decay_total,
  output logic [rpu_pkg::TOT_W-1:0]             out_sum_x,
  output logic [rpu_pkg::TOT_W-1:0]             out_sum_y,
  output logic                                  out_rejected
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int CW = rpu_pkg::CNT_W;
  localparam int TW = rpu_pkg::TOT_W;
  localparam int PW = rpu_pkg::PROP_W;
  localparam int SW = rpu_pkg::SUM_W;
  localparam int RW = rpu_pkg::RATE_W;
  localparam int AW = rpu_pkg::ADDR_W;

  logic [1:0] state_r, state_nxt;

  // control state
  logic [RW-1:0] x_rate_r, y_rate_r;
  logic [TW-1:0] tot_x_r, tot_y_r;
  logic [SW-1:0] psum_r;
  logic [rpu_pkg::BINS-1:0] vld_r;
  logic out_valid_r;

  // per-item payload registers
  logic [rpu_pkg::CMD_W-1:0] cmd_r;
  logic [AW-1:0]             addr_r;
  logic [CW-1:0]             ld_x_r, ld_y_r;
  logic                      bin_ok_r, hit_r;
  logic [CW-1:0]             old_x_r, old_y_r, nx_r, ny_r;
  logic [PW-1:0]             old_p_r, np_r;
  logic [31:0]               p1_r;
  logic                      rej_r;
  logic [TW-1:0]             tx_new_r, ty_new_r;
  logic [SW-1:0]             xj_r, yj_r;

  // output registers
  logic [CW-1:0] o_x_r, o_y_r;
  logic [PW-1:0] o_p_r;
  logic [SW-1:0] o_sum_r, o_xj_r, o_yj_r;
  logic [TW-1:0] o_tx_r, o_ty_r;
  logic          o_rej_r;

  logic in_fire, fin_go, mem_we;
  logic [AW-1:0] raddr;
  rpu_pkg::bin_rec_t rd_rec, wr_rec;
  logic [rpu_pkg::REC_W-1:0] rdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign mem_we   = fin_go && !rej_r;
  assign raddr    = in_bin[AW-1:0];

  assign wr_rec.x    = nx_r;
  assign wr_rec.y    = ny_r;
  assign wr_rec.prop = np_r;
  assign rd_rec      = rpu_pkg::bin_rec_t'(rdata);

  rpu_ram #(
    .WIDTH (rpu_pkg::REC_W),
    .DEPTH (rpu_pkg::BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (wr_rec),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---- stage CALC: current bin values and the event's effect
  logic [CW-1:0] cur_x, cur_y, c_nx, c_ny, c_nm1;
  logic [PW-1:0] cur_p;
  logic          c_rej;

  always_comb begin
    // unwritten or out-of-range bins read as zero
    if (hit_r && bin_ok_r) begin
      cur_x = rd_rec.x;
      cur_y = rd_rec.y;
      cur_p = rd_rec.prop;
    end else begin
      cur_x = '0;
      cur_y = '0;
      cur_p = '0;
    end
    c_nx  = cur_x;
    c_ny  = cur_y;
    c_rej = !bin_ok_r;
    if (bin_ok_r) begin
      unique case (cmd_r)
        rpu_pkg::CMD_MAKE_X: begin
          if (cur_x >= rpu_pkg::MAX_CNT) c_rej = 1'b1;
          else c_nx = cur_x + CW'(1);
        end
        rpu_pkg::CMD_DECAY_X: begin
          if (cur_x == '0) c_rej = 1'b1;
          else c_nx = cur_x - CW'(1);
        end
        rpu_pkg::CMD_MAKE_Y: begin
          if (cur_y >= rpu_pkg::MAX_CNT) c_rej = 1'b1;
          else c_ny = cur_y + CW'(1);
        end
        rpu_pkg::CMD_TRIMER: begin
          if (cur_x >= rpu_pkg::MAX_CNT || cur_y == '0) c_rej = 1'b1;
          else begin
            c_nx = cur_x + CW'(1);
            c_ny = cur_y - CW'(1);
          end
        end
        rpu_pkg::CMD_LOAD: begin
          if (ld_x_r > rpu_pkg::MAX_CNT || ld_y_r > rpu_pkg::MAX_CNT) c_rej = 1'b1;
          else begin
            c_nx = ld_x_r;
            c_ny = ld_y_r;
          end
        end
        default: c_rej = 1'b1;
      endcase
    end
    if (c_rej) begin
      c_nx = cur_x;
      c_ny = cur_y;
    end
    // x-1 wraps at x==0, where the product is zero anyway
    c_nm1 = c_nx - CW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CALC;
      S_CALC:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_rate_r    <= '0;
      y_rate_r    <= '0;
      tot_x_r     <= '0;
      tot_y_r     <= '0;
      psum_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rpu_pkg::CFG_X_RATE: x_rate_r <= cfg_wdata;
          rpu_pkg::CFG_Y_RATE: y_rate_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
        tot_x_r       <= tx_new_r;
        tot_y_r       <= ty_new_r;
        psum_r        <= psum_r - SW'(old_p_r) + SW'(np_r);
      end
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_cmd;
      addr_r   <= raddr;
      ld_x_r   <= in_load_x;
      ld_y_r   <= in_load_y;
      bin_ok_r <= ({26'd0, in_bin} < 32'(rpu_pkg::BINS));
      hit_r    <= vld_r[raddr];
    end
    if (state_r == S_CALC) begin
      old_x_r  <= cur_x;
      old_y_r  <= cur_y;
      old_p_r  <= cur_p;
      nx_r     <= c_nx;
      ny_r     <= c_ny;
      rej_r    <= c_rej;
      p1_r     <= {16'd0, c_nx} * {16'd0, c_nm1};
      tx_new_r <= tot_x_r - TW'(cur_x) + TW'(c_nx);
      ty_new_r <= tot_y_r - TW'(cur_y) + TW'(c_ny);
    end
    if (state_r == S_MUL) begin
      np_r <= {16'd0, p1_r} * {32'd0, ny_r};
      xj_r <= {22'd0, x_rate_r} * {32'd0, rej_r ? tot_x_r : tx_new_r};
      yj_r <= {22'd0, y_rate_r} * {32'd0, rej_r ? tot_y_r : ty_new_r};
    end
    if (fin_go) begin
      o_x_r   <= nx_r;
      o_y_r   <= ny_r;
      o_p_r   <= rej_r ? old_p_r : np_r;
      o_sum_r <= rej_r ? psum_r : (psum_r - SW'(old_p_r) + SW'(np_r));
      o_xj_r  <= xj_r;
      o_yj_r  <= yj_r;
      o_tx_r  <= rej_r ? tot_x_r : tx_new_r;
      o_ty_r  <= rej_r ? tot_y_r : ty_new_r;
      o_rej_r <= rej_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_x          = o_x_r;
  assign out_bin_y          = o_y_r;
  assign out_bin_propensity = o_p_r;
  assign out_trimer_sum     = o_sum_r;
  assign out_x_jump_total   = o_xj_r;
  assign out_y_jump_total   = o_yj_r;
  assign out_decay_total    = {o_tx_r, 1'b0};
  assign out_sum_x          = o_tx_r;
  assign out_sum_y          = o_ty_r;
  assign out_rejected       = o_rej_r;

  // ---- assertions
  a_fire_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_CALC)
    else $error("accepted item did not enter the calc step");

  a_we_fin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_FIN) && !rej_r)
    else $error("bin RAM written outside write-back or on a rejected item");

  a_rej_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && rej_r) |=> $stable(tot_x_r) && $stable(tot_y_r) && $stable(psum_r))
    else $error("rejected item changed the totals");

  a_out_rej_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && rej_r) |-> (nx_r == old_x_r) && (ny_r == old_y_r))
    else $error("rejected item changed the bin counts");

endmodule

`default_nettype wire
